[design/etm_pkg.sv]
// Package for the epoch traffic monitor: item structs, register indexes and
// protocol constants. No dependencies.
package etm_pkg;

  localparam int unsigned MinHeaderWords = 5;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [2:0] RegLocalAddress = 3'd0;
  localparam logic [2:0] RegTrackMode    = 3'd1;
  localparam logic [2:0] RegAlarmEnable  = 3'd2;
  localparam logic [2:0] RegPacketLimit  = 3'd3;
  localparam logic [2:0] RegByteLimit    = 3'd4;
  localparam logic [2:0] RegFlowLimit    = 3'd5;
  localparam logic [2:0] RegSourceLimit  = 3'd6;

  localparam logic [1:0] ModePair  = 2'd1;
  localparam logic [1:0] ModeTuple = 2'd2;

  typedef struct packed {
    logic        command;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [3:0]  header_words;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        is_report;
    logic [3:0]  alarm_mask;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [6:0]  flows;
    logic [6:0]  sources;
    logic [31:0] tcp_packets;
    logic [31:0] udp_packets;
    logic [31:0] icmp_packets;
    logic [31:0] other_packets;
    logic [6:0]  tcp_flows;
    logic [6:0]  udp_flows;
  } out_item_t;

  // Search request and result between the sequencer and the search unit.
  typedef struct packed {
    logic        start;
    logic        do_flow;
    logic        do_source;
  } srch_ctl_t;

  typedef struct packed {
    logic        done;
    logic        flow_hit;
    logic        source_hit;
  } srch_sts_t;

endpackage

[design/etm_search.sv]
// Table search unit: flow and source stores, walked one entry per cycle by
// two shared comparators. Depends on etm_pkg.
module etm_search #(
  parameter int FLOW_ENTRIES = 64,
  parameter int SOURCE_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  etm_pkg::srch_ctl_t        ctl,
  input  logic [1:0]                track_mode,
  input  logic [31:0]               src,
  input  logic [31:0]               dst,
  input  logic [7:0]                proto,
  input  logic [15:0]               sport,
  input  logic [15:0]               dport,
  input  logic [$clog2(FLOW_ENTRIES+1)-1:0]   flow_fill,
  input  logic [$clog2(SOURCE_ENTRIES+1)-1:0] source_fill,
  input  logic                      flow_wr,
  input  logic                      source_wr,
  output etm_pkg::srch_sts_t        sts
);
  localparam int FW = $clog2(FLOW_ENTRIES+1);
  localparam int SW = $clog2(SOURCE_ENTRIES+1);
  localparam int FA = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int SA = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
  localparam int CW = (FW > SW) ? FW : SW;

  logic [63:0] flow_addr_mem [FLOW_ENTRIES];
  logic [39:0] flow_port_mem [FLOW_ENTRIES];
  logic [31:0] source_mem [SOURCE_ENTRIES];

  logic [63:0] fa_rd_r;
  logic [39:0] fp_rd_r;
  logic [31:0] s_rd_r;
  logic        busy_r, fv_r, sv_r;
  logic [CW-1:0] idx_r;
  logic        fhit_r, shit_r, done_r;
  logic [63:0] key_addr;
  logic [39:0] key_port;
  logic        fmatch, smatch;
  logic [FA-1:0] fra;
  logic [SA-1:0] sra;

  assign key_addr = {src, dst};
  assign key_port = {sport, dport, proto};
  assign fra = FA'(idx_r);
  assign sra = SA'(idx_r);

  always_ff @(posedge clk) begin
    if (flow_wr) begin
      flow_addr_mem[FA'(flow_fill)] <= key_addr;
      flow_port_mem[FA'(flow_fill)] <= key_port;
    end
    if (source_wr) begin
      source_mem[SA'(source_fill)] <= src;
    end
    fa_rd_r <= flow_addr_mem[fra];
    fp_rd_r <= flow_port_mem[fra];
    s_rd_r  <= source_mem[sra];
  end

  always_comb begin
    fmatch = 1'b0;
    if (fa_rd_r == key_addr) begin
      if (track_mode == etm_pkg::ModePair) begin
        fmatch = 1'b1;
      end else if (proto == etm_pkg::ProtoIcmp) begin
        fmatch = (fp_rd_r[7:0] == proto);
      end else begin
        fmatch = (fp_rd_r == key_port);
      end
    end
    smatch = (s_rd_r == src);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fv_r   <= 1'b0;
      sv_r   <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
      fhit_r <= 1'b0;
      shit_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        fv_r   <= 1'b0;
        sv_r   <= 1'b0;
        fhit_r <= 1'b0;
        shit_r <= 1'b0;
      end else if (busy_r) begin
        if (fv_r && fmatch && ctl.do_flow) fhit_r <= 1'b1;
        if (sv_r && smatch && ctl.do_source) shit_r <= 1'b1;
        fv_r <= (CW'(idx_r) < CW'(flow_fill));
        sv_r <= (CW'(idx_r) < CW'(source_fill));
        if ((idx_r >= CW'(flow_fill)) && (idx_r >= CW'(source_fill)) && !fv_r && !sv_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;
  assign sts.flow_hit = fhit_r;
  assign sts.source_hit = shit_r;
endmodule

[design/epoch_traffic_monitor.sv]
// Top level of the epoch traffic monitor: configuration, counters, sequencer
// and output register. Depends on etm_pkg and etm_search.
//
// A packet item is searched by a one-entry-per-cycle walk of the flow and source
// tables through a single pair of comparators, up to the larger of the two
// fill levels; a tick or a short header goes straight to the output register
// without a search. The next item is accepted while a result waits.
module epoch_traffic_monitor #(
  parameter int FLOW_ENTRIES = 64,
  parameter int SOURCE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  etm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output etm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int FW = $clog2(FLOW_ENTRIES+1);
  localparam int SW = $clog2(SOURCE_ENTRIES+1);

  typedef enum logic [1:0] {IDLE, SEARCH, UPDATE, EMIT} state_t;

  state_t state_r;
  etm_pkg::in_item_t item_r;
  logic [31:0] local_r, plim_r, blim_r;
  logic [1:0]  mode_r;
  logic [3:0]  aen_r, armed_r;
  logic [6:0]  flim_r, slim_r;
  logic [31:0] pkt_r, byt_r, tcp_r, udp_r, icmp_r, oth_r;
  logic [FW-1:0] ffill_r, ftcp_r, fudp_r;
  logic [SW-1:0] sfill_r;
  logic [3:0]  mask_r;
  logic        report_r;
  logic        ovalid_r;
  etm_pkg::out_item_t odata_r;
  etm_pkg::srch_ctl_t ctl;
  etm_pkg::srch_sts_t sts;
  logic flow_wr, source_wr, do_flow, do_source;
  logic [31:0] pkt_n, byt_n;
  logic [FW-1:0] ffill_n;
  logic [SW-1:0] sfill_n;
  logic [3:0] hit;

  assign do_flow = (mode_r == etm_pkg::ModePair) || (mode_r == etm_pkg::ModeTuple);
  assign do_source = (item_r.dest_address == local_r);
  assign ctl.start = (state_r == IDLE) && in_valid && in_ready &&
                     !in_data.command && (in_data.header_words >= 4'(etm_pkg::MinHeaderWords));
  assign ctl.do_flow = do_flow;
  assign ctl.do_source = do_source;
  assign flow_wr = (state_r == UPDATE) && do_flow && !sts.flow_hit &&
                   (ffill_r < FW'(FLOW_ENTRIES));
  assign source_wr = (state_r == UPDATE) && do_source && !sts.source_hit &&
                     (sfill_r < SW'(SOURCE_ENTRIES));
  assign pkt_n = pkt_r + 32'd1;
  assign byt_n = byt_r + 32'(item_r.packet_length);
  assign ffill_n = flow_wr ? ffill_r + 1'b1 : ffill_r;
  assign sfill_n = source_wr ? sfill_r + 1'b1 : sfill_r;
  assign hit = {(32'(sfill_n) > 32'(slim_r)), (32'(ffill_n) > 32'(flim_r)),
                (byt_n > blim_r), (pkt_n > plim_r)};

  etm_search #(.FLOW_ENTRIES(FLOW_ENTRIES), .SOURCE_ENTRIES(SOURCE_ENTRIES)) u_search (
    .clk, .rst_n, .ctl, .track_mode(mode_r),
    .src(item_r.source_address), .dst(item_r.dest_address), .proto(item_r.protocol),
    .sport(item_r.src_port), .dport(item_r.dest_port),
    .flow_fill(ffill_r), .source_fill(sfill_r),
    .flow_wr, .source_wr, .sts
  );

  assign in_ready = (state_r == IDLE);
  assign out_valid = ovalid_r;
  assign out_data = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_r <= '0; mode_r <= '0; aen_r <= '0; plim_r <= '0;
      blim_r <= '0; flim_r <= '0; slim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        etm_pkg::RegLocalAddress: local_r <= cfg_data;
        etm_pkg::RegTrackMode:    mode_r <= cfg_data[1:0];
        etm_pkg::RegAlarmEnable:  aen_r <= cfg_data[3:0];
        etm_pkg::RegPacketLimit:  plim_r <= cfg_data;
        etm_pkg::RegByteLimit:    blim_r <= cfg_data;
        etm_pkg::RegFlowLimit:    flim_r <= cfg_data[6:0];
        etm_pkg::RegSourceLimit:  slim_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE; ovalid_r <= 1'b0; armed_r <= '1;
      pkt_r <= '0; byt_r <= '0; tcp_r <= '0; udp_r <= '0; icmp_r <= '0; oth_r <= '0;
      ffill_r <= '0; ftcp_r <= '0; fudp_r <= '0; sfill_r <= '0;
      mask_r <= '0; report_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ready && (state_r != EMIT)) ovalid_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            mask_r <= '0;
            report_r <= in_data.command;
            if (ctl.start) state_r <= SEARCH;
            else state_r <= EMIT;
          end
        end
        SEARCH: begin
          if (sts.done) state_r <= UPDATE;
        end
        UPDATE: begin
          pkt_r <= pkt_n;
          byt_r <= byt_n;
          priority if (item_r.protocol == etm_pkg::ProtoTcp) tcp_r <= tcp_r + 32'd1;
          else if (item_r.protocol == etm_pkg::ProtoUdp) udp_r <= udp_r + 32'd1;
          else if (item_r.protocol == etm_pkg::ProtoIcmp) icmp_r <= icmp_r + 32'd1;
          else if (item_r.protocol != 8'd0) oth_r <= oth_r + 32'd1;
          ffill_r <= ffill_n;
          sfill_r <= sfill_n;
          if (flow_wr && item_r.protocol == etm_pkg::ProtoTcp) ftcp_r <= ftcp_r + 1'b1;
          if (flow_wr && item_r.protocol == etm_pkg::ProtoUdp) fudp_r <= fudp_r + 1'b1;
          mask_r <= hit & aen_r & armed_r;
          armed_r <= armed_r & ~(hit & aen_r);
          state_r <= EMIT;
        end
        EMIT: begin
          if (!ovalid_r || out_ready) begin
            ovalid_r <= 1'b1;
            odata_r.is_report <= report_r;
            odata_r.alarm_mask <= mask_r;
            odata_r.packets <= pkt_r;
            odata_r.bytes <= byt_r;
            odata_r.flows <= 7'(ffill_r);
            odata_r.sources <= 7'(sfill_r);
            odata_r.tcp_packets <= tcp_r;
            odata_r.udp_packets <= udp_r;
            odata_r.icmp_packets <= icmp_r;
            odata_r.other_packets <= oth_r;
            odata_r.tcp_flows <= 7'(ftcp_r);
            odata_r.udp_flows <= 7'(fudp_r);
            if (report_r) begin
              pkt_r <= '0; byt_r <= '0; tcp_r <= '0; udp_r <= '0; icmp_r <= '0;
              oth_r <= '0; ffill_r <= '0; ftcp_r <= '0; fudp_r <= '0; sfill_r <= '0;
              armed_r <= '1;
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule

[design/etm_checker.sv]
// Port-level checker for the epoch traffic monitor, bound to the top level.
// Depends on etm_pkg.
module etm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input etm_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed while stalled.");
  a_report_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_report |-> out_data.alarm_mask == 4'd0)
    else $error("Report item carries alarms.");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while busy.");
  a_flows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tcp_flows + out_data.udp_flows) <= 8'(out_data.flows))
    else $error("Per-protocol flows exceed flows.");
endmodule

bind epoch_traffic_monitor etm_checker u_etm_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

[verif/epoch_traffic_monitor_test.sv]
// Self-checking testbench for the epoch traffic monitor: directed and random
// packet and tick items against a scoreboard with its own traffic predictor.
// Depends on etm_pkg and the epoch_traffic_monitor RTL.
`timescale 1ns / 100ps

module epoch_traffic_monitor_test;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int TableSize = 64;

  class traffic_scoreboard;
    logic [31:0] local_addr, pkt_limit, byte_limit;
    logic [1:0]  mode;
    logic [3:0]  enable, armed;
    logic [6:0]  flow_limit, src_limit;
    logic [31:0] pkt_total, byte_total;
    logic [31:0] class_count[4];
    logic [63:0] flow_addr[TableSize];
    logic [39:0] flow_key[TableSize];
    logic [6:0]  flow_fill, src_fill;
    logic [6:0]  flow_class[2];
    logic [31:0] src_table[TableSize];
    etm_pkg::out_item_t expected_q[$];
    int          mismatches;

    function new();
      local_addr = '0; pkt_limit = '0; byte_limit = '0; mode = '0;
      enable = '0; flow_limit = '0; src_limit = '0; mismatches = 0;
      clear_epoch();
    endfunction

    function void clear_epoch();
      pkt_total = '0; byte_total = '0;
      foreach (class_count[i]) class_count[i] = '0;
      flow_fill = '0; src_fill = '0;
      flow_class[0] = '0; flow_class[1] = '0;
      armed = 4'hF;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      unique case (idx)
        etm_pkg::RegLocalAddress: local_addr = data;
        etm_pkg::RegTrackMode:    mode = data[1:0];
        etm_pkg::RegAlarmEnable:  enable = data[3:0];
        etm_pkg::RegPacketLimit:  pkt_limit = data;
        etm_pkg::RegByteLimit:    byte_limit = data;
        etm_pkg::RegFlowLimit:    flow_limit = data[6:0];
        etm_pkg::RegSourceLimit:  src_limit = data[6:0];
        default: ;
      endcase
    endfunction

    function etm_pkg::out_item_t snapshot(logic report, logic [3:0] mask);
      etm_pkg::out_item_t o;
      o.is_report = report; o.alarm_mask = mask;
      o.packets = pkt_total; o.bytes = byte_total;
      o.flows = flow_fill; o.sources = src_fill;
      o.tcp_packets = class_count[0]; o.udp_packets = class_count[1];
      o.icmp_packets = class_count[2]; o.other_packets = class_count[3];
      o.tcp_flows = flow_class[0]; o.udp_flows = flow_class[1];
      return o;
    endfunction

    function void track_flow(etm_pkg::in_item_t it);
      logic [63:0] addr;
      logic [39:0] key;
      addr = {it.source_address, it.dest_address};
      key = {it.src_port, it.dest_port, it.protocol};
      for (int i = 0; i < flow_fill; i++) begin
        if (flow_addr[i] == addr) begin
          if (mode == etm_pkg::ModePair) return;
          if (it.protocol == etm_pkg::ProtoIcmp) begin
            if (flow_key[i][7:0] == it.protocol) return;
          end else if (flow_key[i] == key) begin
            return;
          end
        end
      end
      if (flow_fill >= TableSize) return;
      flow_addr[flow_fill] = addr;
      flow_key[flow_fill] = key;
      flow_fill++;
      if (it.protocol == etm_pkg::ProtoTcp) flow_class[0]++;
      else if (it.protocol == etm_pkg::ProtoUdp) flow_class[1]++;
    endfunction

    function void track_source(logic [31:0] src);
      for (int i = 0; i < src_fill; i++)
        if (src_table[i] == src) return;
      if (src_fill >= TableSize) return;
      src_table[src_fill] = src;
      src_fill++;
    endfunction

    function void note_input(etm_pkg::in_item_t it);
      logic [3:0] hit, fired;
      if (it.command) begin
        expected_q.push_back(snapshot(1'b1, 4'h0));
        clear_epoch();
        return;
      end
      if (it.header_words < etm_pkg::MinHeaderWords) begin
        expected_q.push_back(snapshot(1'b0, 4'h0));
        return;
      end
      if (mode == etm_pkg::ModePair || mode == etm_pkg::ModeTuple) track_flow(it);
      pkt_total++;
      if (it.protocol == etm_pkg::ProtoTcp) class_count[0]++;
      else if (it.protocol == etm_pkg::ProtoUdp) class_count[1]++;
      else if (it.protocol == etm_pkg::ProtoIcmp) class_count[2]++;
      else if (it.protocol != 8'd0) class_count[3]++;
      byte_total += it.packet_length;
      if (it.dest_address == local_addr) track_source(it.source_address);
      hit = {src_fill > src_limit, flow_fill > flow_limit,
             byte_total > byte_limit, pkt_total > pkt_limit};
      fired = hit & enable & armed;
      armed &= ~fired;
      expected_q.push_back(snapshot(1'b0, fired));
    endfunction

    function void check_result(etm_pkg::out_item_t got);
      etm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch\n  expected %h\n  actual   %h", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  etm_pkg::in_item_t  in_data;
  etm_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  traffic_scoreboard sb = new();
  int          send_idle, recv_idle, pool_top;
  logic [31:0] addr_pool[96];

  epoch_traffic_monitor i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(etm_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic etm_pkg::in_item_t make_packet(logic [31:0] src, logic [31:0] dst,
                                                    logic [7:0] proto, logic [15:0] sp,
                                                    logic [15:0] dp, logic [3:0] hw,
                                                    logic [15:0] len);
    etm_pkg::in_item_t it;
    it = '{1'b0, src, dst, proto, sp, dp, hw, len};
    return it;
  endfunction

  function automatic etm_pkg::in_item_t random_item();
    etm_pkg::in_item_t it;
    int r;
    it.command = ($urandom_range(99) < 2);
    it.source_address = ($urandom_range(9) == 0) ? $urandom
                        : addr_pool[$urandom_range(pool_top)];
    r = $urandom_range(9);
    it.dest_address = (r < 4) ? sb.local_addr
                      : (r < 8) ? addr_pool[$urandom_range(pool_top)] : $urandom;
    r = $urandom_range(9);
    it.protocol = (r == 0) ? 8'd0 : (r < 3) ? etm_pkg::ProtoIcmp
                  : (r < 6) ? etm_pkg::ProtoTcp
                  : (r < 9) ? etm_pkg::ProtoUdp : 8'($urandom);
    it.src_port = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    it.dest_port = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    it.header_words = ($urandom_range(9) == 0) ? 4'($urandom_range(4))
                      : 4'($urandom_range(5, 15));
    it.packet_length = 16'($urandom);
    return it;
  endfunction

  task automatic configure(int phase);
    logic [31:0] v[7];
    unique case (phase)
      0: v = '{addr_pool[3], 32'hFFFF_FFFE, 32'h0000_000F, 32'd10, 32'd5000, 32'd8, 32'd3};
      1: v = '{addr_pool[0], 32'd1, 32'd15, 32'd0, 32'd0, 32'd0, 32'd0};
      2: v = '{addr_pool[5], 32'd3, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64, 32'd64};
      3: v = '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd100, 32'd100, 32'd1, 32'd1};
      4: v = '{addr_pool[7], 32'd2, 32'd15, 32'd200, $urandom, 32'd63, 32'd63};
      default: v = '{$urandom, 32'd1, 32'd10, $urandom_range(300), $urandom,
                     $urandom_range(64), $urandom_range(64)};
    endcase
    for (int i = 0; i < 7; i++) write_reg(3'(i), v[i]);
  endtask

  initial begin
    etm_pkg::in_item_t it;
    rst_n <= 1'b0; in_valid <= 1'b0; in_data <= '0; out_ready <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0; addr_pool[1] = 32'hFFFF_FFFF;
    send_idle = 6; recv_idle = 60; pool_top = 15;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    configure(0);

    send_item(make_packet(32'h0, addr_pool[3], etm_pkg::ProtoTcp, 16'h0, 16'h0, 4'd0,
                          16'hFFFF));
    send_item(make_packet(32'h1, addr_pool[3], etm_pkg::ProtoTcp, 16'h1, 16'h1, 4'd4,
                          16'd40));
    send_item(make_packet(32'h0, addr_pool[3], etm_pkg::ProtoTcp, 16'h0, 16'h0, 4'd5,
                          16'h0));
    send_item(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                          4'd15, 16'hFFFF));
    send_item(make_packet(32'h5, 32'h6, 8'd0, 16'd1, 16'd2, 4'd5, 16'd60));
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoIcmp, 16'd1, 16'd2, 4'd5, 16'd64));
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoIcmp, 16'd9, 16'd8, 4'd6, 16'd64));
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoUdp, 16'd53, 16'd53, 4'd5, 16'd80));
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoUdp, 16'd53, 16'd54, 4'd5, 16'd80));
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoTcp, 16'd80, 16'd81, 4'd5,
                          16'd1500));
    send_item(make_packet(32'h7, addr_pool[3], etm_pkg::ProtoTcp, 16'd80, 16'd81, 4'd5,
                          16'd1500));
    send_item(make_packet(32'h8, addr_pool[3], etm_pkg::ProtoUdp, 16'd80, 16'd81, 4'd5,
                          16'd9));
    send_item(make_packet(32'h9, addr_pool[3], 8'd47, 16'd0, 16'd0, 4'd5, 16'd9));
    it = '0; it.command = 1'b1;
    send_item(it);
    send_item(make_packet(32'h5, 32'h6, etm_pkg::ProtoTcp, 16'd80, 16'd81, 4'd5,
                          16'd100));

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin send_idle = 60; recv_idle = 6; end
      if (phase == 4) begin send_idle = 0; recv_idle = 0; end
      pool_top = (phase % 2 == 0) ? 15 : 95;
      if (phase != 0) begin
        in_valid <= 1'b0;
        wait_drained();
        configure(phase);
      end
      for (int n = 0; n < 240; n++) begin
        if (phase == 1 && n == 100) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_item(random_item());
      end
    end
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("epoch_traffic_monitor regression: pass");
    end else begin
      $display("epoch_traffic_monitor regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("epoch_traffic_monitor regression: fail");
    $finish;
  end

endmodule
